// ----- rtl/life_like_automaton_row_step_core_assert.svh -----
// Assertion macros for the RTL of the row step core.
// No dependencies; included inside module bodies after the package import.
`ifndef LIFE_LIKE_AUTOMATON_ROW_STEP_CORE_ASSERT_SVH
`define LIFE_LIKE_AUTOMATON_ROW_STEP_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LLA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LLA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lla_pkg.sv -----
// Shared types and constants for the life-like automaton row step core.
// No dependencies.
`default_nettype none

package lla_pkg;

  localparam int DEFAULT_ROW_WIDTH = 64;
  localparam int COUNT_W           = 4;
  localparam int WIDTH_USE_W       = 7;
  localparam int CFG_DATA_W        = 7;
  localparam int CFG_INDEX_W       = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SURVIVE_LOW  = 3'd0,
    REG_SURVIVE_HIGH = 3'd1,
    REG_BIRTH_LOW    = 3'd2,
    REG_BIRTH_HIGH   = 3'd3,
    REG_WIDTH_IN_USE = 3'd4
  } cfg_reg_t;

  localparam logic [COUNT_W-1:0]     RST_SURVIVE_LOW  = 4'd2;
  localparam logic [COUNT_W-1:0]     RST_SURVIVE_HIGH = 4'd3;
  localparam logic [COUNT_W-1:0]     RST_BIRTH_LOW    = 4'd3;
  localparam logic [COUNT_W-1:0]     RST_BIRTH_HIGH   = 4'd3;
  localparam logic [WIDTH_USE_W-1:0] RST_WIDTH_IN_USE = 7'd64;

  typedef struct packed {
    logic [COUNT_W-1:0] survive_low;
    logic [COUNT_W-1:0] survive_high;
    logic [COUNT_W-1:0] birth_low;
    logic [COUNT_W-1:0] birth_high;
  } rule_t;

endpackage

`default_nettype wire

// ----- rtl/life_like_automaton_row_step_core.sv -----
// Top level of the life-like automaton row step core.
// Depends on lla_pkg, lla_cfg_regs, lla_cell_row and the assert macro header.
//  Input channel (in_valid/in_ready): one grid row per item, row_cells bit i
//  is column i, last_row marks the final row of a generation.
//  Output channel (out_valid/out_ready): next-generation rows in grid order;
//  frame_end marks the last row of the generation.
//  Config port: cfg_we/cfg_index/cfg_data, write only, no wait. Index 0..3
//  are survive_low, survive_high, birth_low, birth_high; index 4 is
//  width_in_use. Other indexes are ignored. Write only while idle.
//  Each row yields the result for the row above it; the first row of a
//  frame yields nothing, the last row yields two results (one if the frame
//  is a single row).
//  Path: an accepted row is held in the job register; each result it owes
//  is loaded into the output register, the second of a last row after the first.
//  Throughput: one row per cycle while the output is not stalled, except that
//  a last row following a held row occupies the cell array once per result.
//  Reset (rst, synchronous): rules return to survive 2..3, birth 3..3,
//  width 64; held rows and both channels clear.
//  Stall: the output register holds its item while out_ready is low; the job
//  register behind it holds one more row, then in_ready drops.
`default_nettype none

module life_like_automaton_row_step_core #(
  parameter int ROW_WIDTH = lla_pkg::DEFAULT_ROW_WIDTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [ROW_WIDTH-1:0]            row_cells,
  input  wire logic                            last_row,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [ROW_WIDTH-1:0]                 next_row,
  output logic                                 frame_end,
  input  wire logic                            cfg_we,
  input  wire logic [lla_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [lla_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lla_pkg::*;
  `include "life_like_automaton_row_step_core_assert.svh"

  rule_t                rules;
  logic [ROW_WIDTH-1:0] used_mask;

  lla_cfg_regs #(.ROW_WIDTH(ROW_WIDTH)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rules     (rules),
    .used_mask (used_mask)
  );

  // Row window: the two most recent rows of the current frame.
  logic [ROW_WIDTH-1:0] upper_row;
  logic [ROW_WIDTH-1:0] middle_row;
  logic                 middle_valid;

  // Job register: snapshot of the window plus the new row, at accept time.
  logic                 job_valid;
  logic                 job_phase;   // 1 once the held-row result has gone out
  logic [ROW_WIDTH-1:0] job_upper;
  logic [ROW_WIDTH-1:0] job_middle;
  logic [ROW_WIDTH-1:0] job_row;
  logic                 job_mv;
  logic                 job_last;

  logic                 in_accept;
  logic [ROW_WIDTH-1:0] row_masked;
  logic                 has_a;       // result for the held row still owed
  logic                 need_b;      // result for the last row itself owed
  logic                 out_can_load;
  logic                 emit;
  logic                 job_retire;
  logic [ROW_WIDTH-1:0] gen_above;
  logic [ROW_WIDTH-1:0] gen_here;
  logic [ROW_WIDTH-1:0] gen_below;
  logic [ROW_WIDTH-1:0] gen_row;

  assign in_accept    = in_valid && in_ready;
  assign row_masked   = row_cells & used_mask;

  assign has_a        = job_mv && !job_phase;
  assign need_b       = job_last;
  assign out_can_load = !out_valid || out_ready;
  assign emit         = job_valid && (has_a || need_b) && out_can_load;
  // A first row with nothing held produces no result and leaves at once.
  assign job_retire   = job_valid &&
                        (!(has_a || need_b) || (out_can_load && !(has_a && need_b)));
  assign in_ready     = !job_valid || job_retire;

  // Operand select: held row first, then the last row against dead cells below.
  always_comb begin
    if (has_a) begin
      gen_above = job_upper;
      gen_here  = job_middle;
      gen_below = job_row;
    end else begin
      gen_above = job_mv ? job_middle : '0;
      gen_here  = job_row;
      gen_below = '0;
    end
  end

  lla_cell_row #(.ROW_WIDTH(ROW_WIDTH)) u_cells (
    .above     (gen_above),
    .here      (gen_here),
    .below     (gen_below),
    .rules     (rules),
    .used_mask (used_mask),
    .next_row  (gen_row)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_row    <= '0;
      middle_row   <= '0;
      middle_valid <= 1'b0;
      job_valid    <= 1'b0;
      job_phase    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (in_accept) begin
        job_valid <= 1'b1;
        job_phase <= 1'b0;
        if (last_row) begin
          upper_row    <= '0;
          middle_row   <= '0;
          middle_valid <= 1'b0;
        end else begin
          upper_row    <= middle_valid ? middle_row : '0;
          middle_row   <= row_masked;
          middle_valid <= 1'b1;
        end
      end else if (job_retire) begin
        job_valid <= 1'b0;
        job_phase <= 1'b0;
      end else if (emit) begin
        job_phase <= 1'b1;
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      job_upper  <= upper_row;
      job_middle <= middle_row;
      job_row    <= row_masked;
      job_mv     <= middle_valid;
      job_last   <= last_row;
    end
    if (emit) begin
      next_row  <= gen_row;
      frame_end <= !has_a;
    end
  end

  `LLA_ASSERT_NEXT(a_last_clears_window, clk, rst, in_accept && last_row, !middle_valid,
                   "last row did not clear the row window")
  `LLA_ASSERT_NEXT(a_row_fills_window, clk, rst, in_accept && !last_row, middle_valid,
                   "non-last row did not fill the row window")
  `LLA_ASSERT_NOW(a_phase_only_two_result, clk, rst, job_phase,
                  job_valid && job_mv && job_last,
                  "second phase on a job that owes one result")
  `LLA_ASSERT_NEXT(a_two_result_job_stays, clk, rst, emit && has_a && need_b,
                   job_valid && job_phase && out_valid && !frame_end,
                   "two-result job lost before its second result")

endmodule

`default_nettype wire

// ----- rtl/lla_cfg_regs.sv -----
// Rule and width registers, plus the used-column mask derived from them.
// Depends on lla_pkg.
`default_nettype none

module lla_cfg_regs #(
  parameter int ROW_WIDTH = lla_pkg::DEFAULT_ROW_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [lla_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [lla_pkg::CFG_DATA_W-1:0]  cfg_data,
  output lla_pkg::rule_t                      rules,
  output logic [ROW_WIDTH-1:0]                used_mask
);
  import lla_pkg::*;

  logic [WIDTH_USE_W-1:0] width_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      rules.survive_low  <= RST_SURVIVE_LOW;
      rules.survive_high <= RST_SURVIVE_HIGH;
      rules.birth_low    <= RST_BIRTH_LOW;
      rules.birth_high   <= RST_BIRTH_HIGH;
      width_in_use       <= RST_WIDTH_IN_USE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SURVIVE_LOW:  rules.survive_low  <= cfg_data[COUNT_W-1:0];
        REG_SURVIVE_HIGH: rules.survive_high <= cfg_data[COUNT_W-1:0];
        REG_BIRTH_LOW:    rules.birth_low    <= cfg_data[COUNT_W-1:0];
        REG_BIRTH_HIGH:   rules.birth_high   <= cfg_data[COUNT_W-1:0];
        REG_WIDTH_IN_USE: width_in_use       <= cfg_data[WIDTH_USE_W-1:0];
        default: ;
      endcase
    end
  end

  // Column i is live when the used width exceeds i; columns past ROW_WIDTH don't exist.
  for (genvar i = 0; i < ROW_WIDTH; i++) begin : g_mask
    assign used_mask[i] = (width_in_use > WIDTH_USE_W'(i));
  end

endmodule

`default_nettype wire

// ----- rtl/lla_cell_row.sv -----
// One row of automaton cells: Moore neighbor count and rule check per column.
// Depends on lla_pkg.
`default_nettype none

module lla_cell_row #(
  parameter int ROW_WIDTH = lla_pkg::DEFAULT_ROW_WIDTH
) (
  input  wire logic [ROW_WIDTH-1:0] above,
  input  wire logic [ROW_WIDTH-1:0] here,
  input  wire logic [ROW_WIDTH-1:0] below,
  input  wire lla_pkg::rule_t       rules,
  input  wire logic [ROW_WIDTH-1:0] used_mask,
  output logic [ROW_WIDTH-1:0]      next_row
);
  import lla_pkg::*;

  // Dead padding on both edges; column i sits at index i+1.
  logic [ROW_WIDTH+1:0] a_pad;
  logic [ROW_WIDTH+1:0] h_pad;
  logic [ROW_WIDTH+1:0] b_pad;

  assign a_pad = {1'b0, above & used_mask, 1'b0};
  assign h_pad = {1'b0, here  & used_mask, 1'b0};
  assign b_pad = {1'b0, below & used_mask, 1'b0};

  for (genvar i = 0; i < ROW_WIDTH; i++) begin : g_cell
    logic [COUNT_W-1:0] count;
    logic               alive;

    assign count = COUNT_W'(a_pad[i]) + COUNT_W'(a_pad[i+1]) + COUNT_W'(a_pad[i+2])
                 + COUNT_W'(h_pad[i])                        + COUNT_W'(h_pad[i+2])
                 + COUNT_W'(b_pad[i]) + COUNT_W'(b_pad[i+1]) + COUNT_W'(b_pad[i+2]);

    always_comb begin
      if (h_pad[i+1]) begin
        alive = (count >= rules.survive_low) && (count <= rules.survive_high);
      end else begin
        alive = (count >= rules.birth_low) && (count <= rules.birth_high);
      end
    end

    assign next_row[i] = alive & used_mask[i];
  end

endmodule

`default_nettype wire
